/* src/tpc_pkg.sv */
`default_nettype none

package tpc_pkg;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_CHECKSUM  = 3'd2;
    localparam logic [2:0] ST_MAGIC     = 3'd3;
    localparam logic [2:0] ST_LENGTH    = 3'd4;

    // packet kinds
    localparam logic [2:0] KIND_UNKNOWN  = 3'd0;
    localparam logic [2:0] KIND_HK1      = 3'd1;
    localparam logic [2:0] KIND_HK2      = 3'd2;
    localparam logic [2:0] KIND_HK4      = 3'd3;
    localparam logic [2:0] KIND_COMMAND  = 3'd4;
    localparam logic [2:0] KIND_HEADER   = 3'd5;
    localparam logic [2:0] KIND_WAVEFORM = 3'd6;

    // inner type codes and their expected inner lengths
    localparam logic [7:0] TYPE_HK1      = 8'h10;
    localparam logic [7:0] TYPE_HK2      = 8'h11;
    localparam logic [7:0] TYPE_HK4      = 8'h13;
    localparam logic [7:0] TYPE_COMMAND  = 8'h00;
    localparam logic [3:0] TYPE_HEADER   = 4'h5;
    localparam logic [3:0] TYPE_WAVEFORM = 4'h6;

    localparam logic [7:0] LEN_HK1       = 8'd29;
    localparam logic [7:0] LEN_HK2       = 8'd77;
    localparam logic [7:0] LEN_HK4       = 8'd83;
    localparam logic [7:0] LEN_COMMAND   = 8'd15;
    localparam logic [7:0] LEN_HEADER    = 8'd101;

    localparam int WRAPPER_BYTES = 10;
    localparam logic [15:0] MAGIC_RESET = 16'hBEFE;

    // register map
    localparam logic [0:0] REG_MAGIC = 1'b0;

    localparam int TDATA_OUT_W = 104;

    typedef struct packed {
        logic [2:0] kind;
        logic       check_len;
        logic [7:0] want_len;
    } t_class;

    function automatic t_class classify(input logic [7:0] inner_type);
        t_class c;
        c = '{kind: KIND_UNKNOWN, check_len: 1'b0, want_len: 8'd0};
        if (inner_type == TYPE_HK1) begin
            c = '{kind: KIND_HK1, check_len: 1'b1, want_len: LEN_HK1};
        end else if (inner_type == TYPE_HK2) begin
            c = '{kind: KIND_HK2, check_len: 1'b1, want_len: LEN_HK2};
        end else if (inner_type == TYPE_HK4) begin
            c = '{kind: KIND_HK4, check_len: 1'b1, want_len: LEN_HK4};
        end else if (inner_type == TYPE_COMMAND) begin
            c = '{kind: KIND_COMMAND, check_len: 1'b1, want_len: LEN_COMMAND};
        end else if (inner_type[7:4] == TYPE_HEADER) begin
            c = '{kind: KIND_HEADER, check_len: 1'b1, want_len: LEN_HEADER};
        end else if (inner_type[7:4] == TYPE_WAVEFORM) begin
            c = '{kind: KIND_WAVEFORM, check_len: 1'b0, want_len: 8'd0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* src/telemetry_packet_checker_unit.sv */
`default_nettype none

// Channel   | Dir | Handshake               | Payload
// ----------+-----+-------------------------+------------------------------------------
// s (bytes) | in  | i_s_tvalid / o_s_tready | tdata[7:0] data_byte, tlast last_byte
// m (verdict)| out | o_m_tvalid / i_m_tready | tdata: status, kind, event_number, ...
// apb       | in  | psel/penable/pwrite     | magic_word at address 0, pready always 1
//
// One byte per clock sustained, unless a final byte waits on a stalled verdict. A byte
// is held in the input register, then updates the packet state; on the final byte the
// verdict and o_m_tvalid are loaded into the output register as that byte is processed.
// Only a final byte waits for a stalled verdict; other bytes keep flowing.
// Reset is synchronous, active low, clears the packet state and sets magic_word to 0xBEFE.
module telemetry_packet_checker_unit
    import tpc_pkg::*;
#(
    parameter int COUNT_LIMIT = 4095
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_s_tvalid,
    output logic                   o_s_tready,
    input  wire  [7:0]             i_s_tdata,   // [7:0] data_byte
    input  wire                    i_s_tlast,   // last_byte
    output logic                   o_m_tvalid,
    input  wire                    i_m_tready,
    // [2:0] status, [5:3] kind, [37:6] event_number, [69:38] tick_count,
    // [77:70] inner_type, [85:78] inner_length, [97:86] packet_bytes, [103:98] zero
    output logic [TDATA_OUT_W-1:0] o_m_tdata,
    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire  [2:0]             paddr,
    input  wire  [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int CW = $clog2(COUNT_LIMIT + 1);
    localparam int OW = (CW > 12) ? CW : 12;
    localparam logic [CW-1:0] LIMIT = CW'(COUNT_LIMIT);

    // configuration
    logic [15:0] r_magic;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic <= MAGIC_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAGIC) begin
            r_magic <= pwdata[15:0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == REG_MAGIC) begin
            prdata = {16'd0, r_magic};
        end
    end

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       w_out_free;
    logic       w_proc;

    assign w_out_free = !o_m_tvalid || i_m_tready;
    assign w_proc     = r_in_valid && (!r_in_last || w_out_free);
    assign o_s_tready = !r_in_valid || w_proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    // packet state
    logic [CW-1:0] r_count, n_count;
    logic [15:0]   r_total, n_total;   // sum of all complete words
    logic [7:0]    r_low, n_low;
    logic [15:0]   r_first, n_first;
    logic [31:0]   r_event, n_event;
    logic [31:0]   r_tick, n_tick;
    logic [7:0]    r_len, n_len;
    logic [7:0]    r_type, n_type;

    always_comb begin
        n_count = r_count;
        n_total = r_total;
        n_low   = r_low;
        n_first = r_first;
        n_event = r_event;
        n_tick  = r_tick;
        n_len   = r_len;
        n_type  = r_type;
        if (r_count < LIMIT) begin
            if (!r_count[0]) begin
                n_low = r_in_byte;
            end else begin
                n_total = r_total + {r_in_byte, r_low};
                if (r_count == CW'(1)) begin
                    n_first = {r_in_byte, r_low};
                end
            end
            if (r_count == CW'(2)) n_event[7:0]   = r_in_byte;
            if (r_count == CW'(3)) n_event[15:8]  = r_in_byte;
            if (r_count == CW'(4)) n_event[23:16] = r_in_byte;
            if (r_count == CW'(5)) n_event[31:24] = r_in_byte;
            if (r_count == CW'(6)) n_tick[7:0]    = r_in_byte;
            if (r_count == CW'(7)) n_tick[15:8]   = r_in_byte;
            if (r_count == CW'(8)) n_tick[23:16]  = r_in_byte;
            if (r_count == CW'(9)) n_tick[31:24]  = r_in_byte;
            if (r_count == CW'(10)) n_len         = r_in_byte;
            if (r_count == CW'(11)) n_type        = r_in_byte;
            n_count = r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_proc && r_in_last)) begin
            r_count <= '0;
            r_total <= '0;
            r_low   <= '0;
            r_first <= '0;
            r_event <= '0;
            r_tick  <= '0;
            r_len   <= '0;
            r_type  <= '0;
        end else if (w_proc) begin
            r_count <= n_count;
            r_total <= n_total;
            r_low   <= n_low;
            r_first <= n_first;
            r_event <= n_event;
            r_tick  <= n_tick;
            r_len   <= n_len;
            r_type  <= n_type;
        end
    end

    // verdict
    t_class        w_class;
    logic [2:0]    w_status;
    logic [2:0]    w_kind;
    logic [OW-1:0] w_count_ext;

    assign w_class     = classify(n_type);
    assign w_count_ext = OW'(n_count);

    always_comb begin
        w_status = ST_OK;
        w_kind   = KIND_UNKNOWN;
        if (n_count < CW'(WRAPPER_BYTES) || n_count[0] || n_count >= LIMIT) begin
            w_status = ST_SHORT;
        end else if (n_total != 16'd0) begin
            w_status = ST_CHECKSUM;
        end else if (n_first != r_magic) begin
            w_status = ST_MAGIC;
        end else if (n_count >= CW'(WRAPPER_BYTES + 2)) begin
            w_kind = w_class.kind;
            if (w_class.check_len && n_len != w_class.want_len) begin
                w_status = ST_LENGTH;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_tvalid <= 1'b0;
        end else if (w_proc && r_in_last) begin
            o_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            o_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && r_in_last) begin
            o_m_tdata <= {6'd0, w_count_ext[11:0], n_len, n_type, n_tick, n_event,
                          w_kind, w_status};
        end
    end

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(w_proc && r_in_last))
        else $error("verdict without a final byte");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[2:0] <= ST_LENGTH)
        else $error("status out of range");

    a_rejected_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[2:0] == ST_SHORT || o_m_tdata[2:0] == ST_CHECKSUM
                        || o_m_tdata[2:0] == ST_MAGIC)) |-> o_m_tdata[5:3] == KIND_UNKNOWN)
        else $error("rejected packet carries a kind");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LIMIT)
        else $error("byte count past limit");

    a_last_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_last && o_m_tvalid && !i_m_tready) |=> r_in_valid)
        else $error("final byte dropped while verdict stalled");

endmodule

`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import tpc_pkg::*;

    localparam int PKT_LIMIT = 4095;
    localparam logic [2:0] MAGIC_ADDR = {REG_MAGIC, 2'b00};

    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;

    localparam int FLAW_NONE = 0;
    localparam int FLAW_SUM  = 1;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_item_t;

    // mirrors o_m_tdata, highest field first
    typedef struct packed {
        logic [5:0]  pad;
        logic [11:0] packet_bytes;
        logic [7:0]  inner_length;
        logic [7:0]  inner_type;
        logic [31:0] tick_count;
        logic [31:0] event_number;
        logic [2:0]  kind;
        logic [2:0]  status;
    } verdict_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [7:0]             i_s_tdata = 8'h00;   // [7:0] data_byte
    logic                   i_s_tlast = 1'b0;    // last_byte
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // [2:0] status, [5:3] kind, [37:6] event_number, [69:38] tick_count,
    // [77:70] inner_type, [85:78] inner_length, [97:86] packet_bytes
    logic [TDATA_OUT_W-1:0] o_m_tdata;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [2:0]             paddr = 3'd0;
    logic [31:0]            pwdata = 32'd0;
    logic [31:0]            prdata;
    logic                   pready;

    telemetry_packet_checker_unit #(
        .COUNT_LIMIT(PKT_LIMIT)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    byte_item_t  pending_bytes[$];
    verdict_t    verdicts_due[$];
    logic [7:0]  pkt_bytes[$];

    int          cyc = 0;
    int          err_count = 0;
    int          bytes_queued = 0;
    int          bytes_accepted = 0;
    logic        byte_taken = 1'b0;

    // packet checker state as seen by the scoreboard
    logic [15:0] magic_now;
    int          pc_count;
    logic [15:0] pc_sum;
    logic [7:0]  pc_low;
    logic [15:0] pc_held;
    logic [15:0] pc_first;
    logic [31:0] pc_event;
    logic [31:0] pc_tick;
    logic [7:0]  pc_len;
    logic [7:0]  pc_type;

    // {kind, expected inner length}; length 0 means no length check
    function automatic logic [10:0] sort_type(input logic [7:0] t);
        if (t == TYPE_HK1)               return {KIND_HK1, LEN_HK1};
        if (t == TYPE_HK2)               return {KIND_HK2, LEN_HK2};
        if (t == TYPE_HK4)               return {KIND_HK4, LEN_HK4};
        if (t == TYPE_COMMAND)           return {KIND_COMMAND, LEN_COMMAND};
        if (t[7:4] == TYPE_HEADER)       return {KIND_HEADER, LEN_HEADER};
        if (t[7:4] == TYPE_WAVEFORM)     return {KIND_WAVEFORM, 8'd0};
        return {KIND_UNKNOWN, 8'd0};
    endfunction

    task automatic clear_packet_state();
        pc_count = 0;
        pc_sum   = 16'd0;
        pc_low   = 8'd0;
        pc_held  = 16'd0;
        pc_first = 16'd0;
        pc_event = 32'd0;
        pc_tick  = 32'd0;
        pc_len   = 8'd0;
        pc_type  = 8'd0;
    endtask

    task automatic judge_byte(input logic [7:0] b, input logic last);
        verdict_t    v;
        logic [10:0] sorted;
        logic [15:0] word;
        int          idx;
        if (pc_count < PKT_LIMIT) begin
            idx = pc_count;
            if (idx % 2 == 0) begin
                pc_low = b;
            end else begin
                word = {b, pc_low};
                if (idx >= 3) pc_sum = pc_sum + pc_held;
                pc_held = word;
                if (idx == 1) pc_first = word;
            end
            if (idx >= 2 && idx <= 5) begin
                pc_event[8*(idx-2) +: 8] = b;
            end else if (idx >= 6 && idx <= 9) begin
                pc_tick[8*(idx-6) +: 8] = b;
            end else if (idx == 10) begin
                pc_len = b;
            end else if (idx == 11) begin
                pc_type = b;
            end
            pc_count = idx + 1;
        end
        if (!last) return;
        v = '0;
        v.status = ST_OK;
        v.kind = KIND_UNKNOWN;
        if (pc_count < WRAPPER_BYTES || pc_count % 2 != 0 || pc_count >= PKT_LIMIT) begin
            v.status = ST_SHORT;
        end else if (16'(~pc_sum + 16'd1) != pc_held) begin
            v.status = ST_CHECKSUM;
        end else if (pc_first != magic_now) begin
            v.status = ST_MAGIC;
        end else if (pc_count >= WRAPPER_BYTES + 2) begin
            sorted = sort_type(pc_type);
            v.kind = sorted[10:8];
            if (sorted[7:0] != 8'd0 && pc_len != sorted[7:0]) v.status = ST_LENGTH;
        end
        v.event_number = pc_event;
        v.tick_count   = pc_tick;
        v.inner_type   = pc_type;
        v.inner_length = pc_len;
        v.packet_bytes = 12'(pc_count);
        verdicts_due.insert(verdicts_due.size(), v);
        clear_packet_state();
    endtask

    function automatic logic take_break();
        return (cyc % 1000 < 700) && ($urandom_range(99) < 11);
    endfunction

    // byte driver
    always @(negedge i_clk) begin : byte_driver
        byte_item_t nxt;
        if (i_rst_n && (!i_s_tvalid || byte_taken)) begin
            if (pending_bytes.size() != 0 && !take_break()) begin
                nxt = pending_bytes.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= nxt.data;
                i_s_tlast  <= nxt.last;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
        i_m_tready <= i_rst_n && !take_break();
    end

    // monitor and scoreboard
    always @(posedge i_clk) begin : verdict_monitor
        verdict_t got;
        verdict_t want;
        cyc = cyc + 1;
        byte_taken = 1'b0;
        if (!i_rst_n) begin
            magic_now = MAGIC_RESET;
            clear_packet_state();
        end else begin
            if (psel && penable && pwrite && pready && paddr == MAGIC_ADDR)
                magic_now = pwdata[15:0];
            if (i_s_tvalid && o_s_tready) begin
                byte_taken = 1'b1;
                bytes_accepted = bytes_accepted + 1;
                judge_byte(i_s_tdata, i_s_tlast);
            end
            if (o_m_tvalid && i_m_tready) begin
                got = o_m_tdata;
                if (verdicts_due.size() == 0) begin
                    err_count = err_count + 1;
                    if (err_count <= 10)
                        $display("unexpected verdict: status %0d kind %0d bytes %0d",
                                 got.status, got.kind, got.packet_bytes);
                end else begin
                    want = verdicts_due.pop_front();
                    if (got !== want) begin
                        err_count = err_count + 1;
                        if (err_count <= 10) begin
                            $display("verdict mismatch at cycle %0d", cyc);
                            $display("  expected: st %0d kind %0d ev %h tick %h",
                                     want.status, want.kind, want.event_number,
                                     want.tick_count);
                            $display("            type %h len %h n %0d pad %h",
                                     want.inner_type, want.inner_length,
                                     want.packet_bytes, want.pad);
                            $display("  actual:   st %0d kind %0d ev %h tick %h",
                                     got.status, got.kind, got.event_number,
                                     got.tick_count);
                            $display("            type %h len %h n %0d pad %h",
                                     got.inner_type, got.inner_length,
                                     got.packet_bytes, got.pad);
                        end
                    end
                end
            end
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [15:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= {16'($urandom), value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // hold until every byte is taken and every verdict is back, then let the pipe empty
    task automatic drain();
        do @(negedge i_clk);
        while (bytes_accepted != bytes_queued || verdicts_due.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic make_packet(input int total, input logic [15:0] head, input logic [7:0] ptype,
                               input logic [7:0] plen, input int fill, input int flaw);
        int          body;
        logic [7:0]  b;
        logic [15:0] sum;
        int          pos;
        pkt_bytes.delete();
        body = (total % 2 == 0) ? total - 2 : total;
        for (int i = 0; i < body; i++) begin
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hFF;
                default:   b = 8'($urandom);
            endcase
            if (i < 2)   b = head[8*i +: 8];
            if (i == 10) b = plen;
            if (i == 11) b = ptype;
            pkt_bytes.insert(pkt_bytes.size(), b);
        end
        if (total % 2 == 0) begin
            sum = 16'd0;
            for (int i = 0; i < body; i += 2) sum = sum + {pkt_bytes[i+1], pkt_bytes[i]};
            sum = ~sum + 16'd1;
            pkt_bytes.insert(pkt_bytes.size(), sum[7:0]);
            pkt_bytes.insert(pkt_bytes.size(), sum[15:8]);
            if (flaw == FLAW_SUM) begin
                pos = total - 1 - $urandom_range(1);
                pkt_bytes[pos] = pkt_bytes[pos] ^ (8'h01 << $urandom_range(7));
            end
        end
        for (int i = 0; i < total; i++)
            pending_bytes.insert(pending_bytes.size(),
                                 '{data: pkt_bytes[i], last: (i == total - 1)});
        bytes_queued = bytes_queued + total;
    endtask

    task automatic random_packet(input logic [15:0] magic, output int total);
        int          roll;
        logic [7:0]  ptype;
        logic [7:0]  plen;
        logic [10:0] sorted;
        logic [15:0] head;
        int          flaw;
        roll = $urandom_range(99);
        if (roll < 70)      total = 14 + 2 * $urandom_range(13);
        else if (roll < 80) total = $urandom_range(1) ? 10 : 12;
        else if (roll < 90) total = $urandom_range(1, 13);
        else                total = 15 + 2 * $urandom_range(13);
        case ($urandom_range(6))
            0:       ptype = TYPE_HK1;
            1:       ptype = TYPE_HK2;
            2:       ptype = TYPE_HK4;
            3:       ptype = TYPE_COMMAND;
            4:       ptype = {TYPE_HEADER, 4'($urandom)};
            5:       ptype = {TYPE_WAVEFORM, 4'($urandom)};
            default: ptype = 8'($urandom);
        endcase
        sorted = sort_type(ptype);
        plen = ($urandom_range(99) < 80 && sorted[7:0] != 8'd0) ? sorted[7:0] : 8'($urandom);
        head = ($urandom_range(99) < 85) ? magic : 16'($urandom);
        flaw = ($urandom_range(99) < 10) ? FLAW_SUM : FLAW_NONE;
        make_packet(total, head, ptype, plen, FILL_RANDOM, flaw);
    endtask

    task automatic random_phase(input logic [15:0] magic, input int budget);
        int sent;
        int total;
        sent = 0;
        while (sent < budget) begin
            random_packet(magic, total);
            sent += total;
        end
        drain();
    endtask

    initial begin : main_flow
        logic [15:0] m;
        logic [15:0] magic_pick;
        i_rst_n <= 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset magic, every kind and every rejection path
        m = MAGIC_RESET;
        make_packet(30, m, TYPE_HK1, LEN_HK1, FILL_RANDOM, FLAW_NONE);
        make_packet(40, m, TYPE_HK2, LEN_HK2, FILL_RANDOM, FLAW_NONE);
        make_packet(20, m, TYPE_HK4, LEN_HK4, FILL_RANDOM, FLAW_NONE);
        make_packet(16, m, TYPE_COMMAND, LEN_COMMAND, FILL_RANDOM, FLAW_NONE);
        make_packet(24, m, {TYPE_HEADER, 4'hA}, LEN_HEADER, FILL_RANDOM, FLAW_NONE);
        make_packet(18, m, {TYPE_WAVEFORM, 4'h3}, 8'h5C, FILL_RANDOM, FLAW_NONE);
        make_packet(14, m, 8'h20, 8'h00, FILL_RANDOM, FLAW_NONE);
        make_packet(14, m, 8'hFF, LEN_HK1, FILL_RANDOM, FLAW_NONE);
        make_packet(22, m, TYPE_HK1, LEN_HK2, FILL_RANDOM, FLAW_NONE);
        make_packet(22, m, {TYPE_HEADER, 4'h0}, 8'd100, FILL_RANDOM, FLAW_NONE);
        make_packet(26, m, TYPE_HK4, LEN_HK4, FILL_RANDOM, FLAW_SUM);
        make_packet(26, ~m, TYPE_HK4, LEN_HK4, FILL_RANDOM, FLAW_NONE);
        make_packet(1, m, TYPE_HK1, LEN_HK1, FILL_RANDOM, FLAW_NONE);
        make_packet(9, m, TYPE_HK1, LEN_HK1, FILL_RANDOM, FLAW_NONE);
        make_packet(8, m, TYPE_HK1, LEN_HK1, FILL_RANDOM, FLAW_NONE);
        make_packet(10, m, TYPE_HK1, LEN_HK1, FILL_RANDOM, FLAW_NONE);
        make_packet(11, m, TYPE_HK1, LEN_HK1, FILL_RANDOM, FLAW_NONE);
        make_packet(12, m, TYPE_HK1, LEN_HK1, FILL_RANDOM, FLAW_NONE);
        make_packet(15, m, TYPE_HK1, LEN_HK1, FILL_RANDOM, FLAW_NONE);
        drain();

        apb_write(MAGIC_ADDR, 16'h0000);
        make_packet(20, 16'h0000, TYPE_COMMAND, 8'h00, FILL_ZERO, FLAW_NONE);
        random_phase(16'h0000, 300);

        apb_write(MAGIC_ADDR, 16'hFFFF);
        make_packet(20, 16'hFFFF, 8'hFF, 8'hFF, FILL_ONES, FLAW_NONE);
        random_phase(16'hFFFF, 300);

        magic_pick = 16'($urandom);
        apb_write(MAGIC_ADDR, magic_pick);
        random_phase(magic_pick, 300);

        apb_write(MAGIC_ADDR, MAGIC_RESET);
        random_phase(MAGIC_RESET, 300);

        repeat (10) @(posedge i_clk);
        if (err_count == 0 && verdicts_due.size() == 0) begin
            $display("telemetry_packet_checker_unit regression: pass");
        end else begin
            $display("telemetry_packet_checker_unit regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("telemetry_packet_checker_unit regression: fail");
        $finish;
    end

endmodule
